>>> rtl/qspc_pkg.sv
// ----------------------------------------------------------------------------
// qspc_pkg
// Shared widths, register indexes, reset values and the duty clamp for the
// quadrature servo position controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qspc_pkg;

   // Event codes carried on the request channel
   localparam logic [1:0] OP_ENCODER = 2'd0;
   localparam logic [1:0] OP_STEP    = 2'd1;
   localparam logic [1:0] OP_CONTROL = 2'd2;
   localparam logic [1:0] OP_MS_TICK = 2'd3;

   // Field widths
   localparam int MARGIN_W   = 16;
   localparam int DUTY_W     = 8;
   localparam int GAIN_W     = 16;
   localparam int RATE_W     = 25;
   localparam int STALL_W    = 16;
   localparam int ELAPSED_W  = 24;
   localparam int Q_FRAC     = 24;
   localparam int ACC_W      = ELAPSED_W + RATE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;
   localparam int COUNT_W    = 32;

   // Unity in Q1.24, also the clip point of the error magnitude
   localparam logic [Q_FRAC:0] ONE_Q24 = 25'h100_0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MARGIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DUTY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_RATE   = 3'd5;

   // Register reset values
   localparam logic [MARGIN_W-1:0] RST_STEP_MARGIN = 16'd1;
   localparam logic [DUTY_W-1:0]   RST_MIN_DUTY    = 8'd30;
   localparam logic [DUTY_W-1:0]   RST_MAX_DUTY    = 8'd225;
   localparam logic [GAIN_W-1:0]   RST_PROP_GAIN   = 16'd256;
   localparam logic [GAIN_W-1:0]   RST_INTEG_GAIN  = 16'd77;
   localparam logic [RATE_W-1:0]   RST_SOFT_RATE   = 25'd8389;

   localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

   // Apply the lower bound first, then the upper bound
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W+1:0] d,
                                                    input logic [DUTY_W-1:0] lo,
                                                    input logic [DUTY_W-1:0] hi);
      logic [DUTY_W+1:0] t;
      t = (d < {2'b00, lo}) ? {2'b00, lo} : d;
      if (t > {2'b00, hi}) begin
         t = {2'b00, hi};
      end
      return t[DUTY_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/quadrature_servo_position_controller.sv
// ----------------------------------------------------------------------------
// quadrature_servo_position_controller
// Step/direction DC servo with quadrature feedback. Each request is one event:
// an encoder sample, a step pulse, a control tick or a millisecond tick, and
// each produces exactly one response with the drive outputs, done flag and
// both position counts after the event. Encoder samples, step pulses and
// millisecond ticks go from the idle state straight to the output state,
// which loads the response register once it is free and then frees the
// request side. A control tick forms the error and its magnitude, then runs
// four products (error times P, stall count times I, elapsed time times the
// soft-start slope, duty times the soft-start factor) through one
// shift-and-add multiplier that retires one multiplier bit per cycle and
// stops once the remaining bits are zero; the last product is skipped once
// soft start is over. The run of each product grows with the bit length of
// its multiplier (the gain, the slope or the factor). The drive is then
// applied and the response loaded. The request side stalls while an event
// is in work; the response register lets the next event in while a response
// is still waiting. Registers are to be written through the csr port only
// while no event is in work; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quadrature_servo_position_controller #(
   parameter int POSITION_WIDTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [1:0]                           req_op,
   input  wire                                  req_enc_a,
   input  wire                                  req_enc_b,
   input  wire                                  req_step_dir,
   // response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_motor_enable,
   output logic                                 rsp_motor_dir,
   output logic [qspc_pkg::DUTY_W-1:0]          rsp_pwm_level,
   output logic                                 rsp_step_done,
   output logic signed [qspc_pkg::COUNT_W-1:0]  rsp_actual_count,
   output logic signed [qspc_pkg::COUNT_W-1:0]  rsp_target_count,
   // register write channel
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [qspc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [qspc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int PW = POSITION_WIDTH;
   // magnitude is widened so the clip point and the margin both fit
   localparam int MW = (PW > 25) ? PW : 25;
   // positions are widened so the low count bits always exist
   localparam int OW = (PW > qspc_pkg::COUNT_W) ? PW : qspc_pkg::COUNT_W;

   localparam logic [MW-1:0] MAG_CLIP = MW'(qspc_pkg::ONE_Q24);

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ERR   = 3'd1;
   localparam logic [2:0] ST_MAG   = 3'd2;
   localparam logic [2:0] ST_MLOAD = 3'd3;
   localparam logic [2:0] ST_MRUN  = 3'd4;
   localparam logic [2:0] ST_APPLY = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // Product being formed by the serial multiplier
   localparam logic [1:0] MUL_PROP  = 2'd0;
   localparam logic [1:0] MUL_INTEG = 2'd1;
   localparam logic [1:0] MUL_RAMP  = 2'd2;
   localparam logic [1:0] MUL_SCALE = 2'd3;

   // Registers
   logic [qspc_pkg::MARGIN_W-1:0] margin_ff,  margin_in;
   logic [qspc_pkg::DUTY_W-1:0]   min_ff,     min_in;
   logic [qspc_pkg::DUTY_W-1:0]   max_ff,     max_in;
   logic [qspc_pkg::GAIN_W-1:0]   pgain_ff,   pgain_in;
   logic [qspc_pkg::GAIN_W-1:0]   igain_ff,   igain_in;
   logic [qspc_pkg::RATE_W-1:0]   rate_ff,    rate_in;

   // Controller state
   logic [PW-1:0]                 target_ff,  target_in;
   logic [PW-1:0]                 actual_ff,  actual_in;
   logic [1:0]                    phase_ff,   phase_in;
   logic [qspc_pkg::STALL_W-1:0]  stall_ff,   stall_in;
   logic [qspc_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                          done_ff,    done_in;
   logic                          en_ff,      en_in;
   logic                          dir_ff,     dir_in;
   logic [qspc_pkg::DUTY_W-1:0]   pwm_ff,     pwm_in;

   // Sequencer and datapath
   logic [2:0]                    state_ff,   state_in;
   logic [1:0]                    sel_ff,     sel_in;
   logic [PW-1:0]                 err_ff,     err_in;
   logic [PW-1:0]                 mag_ff,     mag_in;
   logic [qspc_pkg::ACC_W-1:0]    acc_ff,     acc_in;
   logic [qspc_pkg::ACC_W-1:0]    mcand_ff,   mcand_in;
   logic [qspc_pkg::RATE_W-1:0]   mplier_ff,  mplier_in;
   logic [qspc_pkg::DUTY_W-1:0]   pterm_ff,   pterm_in;
   logic [qspc_pkg::DUTY_W-1:0]   duty_ff,    duty_in;
   logic [qspc_pkg::Q_FRAC-1:0]   factor_ff,  factor_in;

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_en_ff,    rsp_en_in;
   logic                          rsp_dir_ff,   rsp_dir_in;
   logic [qspc_pkg::DUTY_W-1:0]   rsp_pwm_ff,   rsp_pwm_in;
   logic                          rsp_done_ff,  rsp_done_in;
   logic [qspc_pkg::COUNT_W-1:0]  rsp_act_ff,   rsp_act_in;
   logic [qspc_pkg::COUNT_W-1:0]  rsp_tgt_ff,   rsp_tgt_in;

   // Helpers
   logic                          accept;
   logic [1:0]                    new_phase;
   logic [MW-1:0]                 mag_ext;
   logic [MW-1:0]                 margin_ext;
   logic [qspc_pkg::Q_FRAC:0]     mag_clip;
   logic [OW-1:0]                 act_ext;
   logic [OW-1:0]                 tgt_ext;
   logic [qspc_pkg::DUTY_W:0]     iterm_sat;
   logic [qspc_pkg::DUTY_W-1:0]   pterm_sat;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Levels 00,01,11,10 map to phases 0,1,2,3
   assign new_phase = {req_enc_a, req_enc_a ^ req_enc_b};

   assign mag_ext    = MW'(mag_ff);
   assign margin_ext = MW'(margin_ff);
   assign mag_clip   = (mag_ext > MAG_CLIP) ? qspc_pkg::ONE_Q24 : mag_ext[qspc_pkg::Q_FRAC:0];
   assign act_ext    = OW'(actual_ff);
   assign tgt_ext    = OW'(target_ff);

   // Saturate the shifted products: above the duty range, P clamps to 255 and I to 256
   assign pterm_sat = (|acc_ff[qspc_pkg::ACC_W-1:16]) ? qspc_pkg::DUTY_FULL : acc_ff[15:8];
   assign iterm_sat = (|acc_ff[qspc_pkg::ACC_W-1:16]) ? 9'h100 : {1'b0, acc_ff[15:8]};

   always_comb begin
      margin_in    = margin_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      pgain_in     = pgain_ff;
      igain_in     = igain_ff;
      rate_in      = rate_ff;
      target_in    = target_ff;
      actual_in    = actual_ff;
      phase_in     = phase_ff;
      stall_in     = stall_ff;
      elapsed_in   = elapsed_ff;
      done_in      = done_ff;
      en_in        = en_ff;
      dir_in       = dir_ff;
      pwm_in       = pwm_ff;
      state_in     = state_ff;
      sel_in       = sel_ff;
      err_in       = err_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      pterm_in     = pterm_ff;
      duty_in      = duty_ff;
      factor_in    = factor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_en_in    = rsp_en_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_pwm_in   = rsp_pwm_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_tgt_in   = rsp_tgt_ff;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            qspc_pkg::CSR_STEP_MARGIN: margin_in = csr_data[qspc_pkg::MARGIN_W-1:0];
            qspc_pkg::CSR_MIN_DUTY:    min_in    = csr_data[qspc_pkg::DUTY_W-1:0];
            qspc_pkg::CSR_MAX_DUTY:    max_in    = csr_data[qspc_pkg::DUTY_W-1:0];
            qspc_pkg::CSR_PROP_GAIN:   pgain_in  = csr_data[qspc_pkg::GAIN_W-1:0];
            qspc_pkg::CSR_INTEG_GAIN:  igain_in  = csr_data[qspc_pkg::GAIN_W-1:0];
            qspc_pkg::CSR_SOFT_RATE:   rate_in   = csr_data[qspc_pkg::RATE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  qspc_pkg::OP_ENCODER: begin
                     // Count one phase forward or back; a double jump only moves the phase
                     if (new_phase == phase_ff + 2'd1) begin
                        actual_in = actual_ff + PW'(1);
                        stall_in  = '0;
                     end else if (new_phase == phase_ff - 2'd1) begin
                        actual_in = actual_ff - PW'(1);
                        stall_in  = '0;
                     end
                     phase_in = new_phase;
                     state_in = ST_OUT;
                  end
                  qspc_pkg::OP_STEP: begin
                     target_in  = req_step_dir ? target_ff + PW'(1) : target_ff - PW'(1);
                     elapsed_in = '0;
                     done_in    = 1'b0;
                     state_in   = ST_OUT;
                  end
                  qspc_pkg::OP_CONTROL: begin
                     if (stall_ff != '1) begin
                        stall_in = stall_ff + qspc_pkg::STALL_W'(1);
                     end
                     state_in = ST_ERR;
                  end
                  default: begin
                     if (elapsed_ff != '1) begin
                        elapsed_in = elapsed_ff + qspc_pkg::ELAPSED_W'(1);
                     end
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_ERR: begin
            err_in   = target_ff - actual_ff;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            mag_in   = err_ff[PW-1] ? -err_ff : err_ff;
            sel_in   = MUL_PROP;
            state_in = ST_MLOAD;
         end
         ST_MLOAD: begin
            acc_in = '0;
            case (sel_ff)
               MUL_PROP: begin
                  mcand_in  = qspc_pkg::ACC_W'(mag_clip);
                  mplier_in = qspc_pkg::RATE_W'(pgain_ff);
               end
               MUL_INTEG: begin
                  mcand_in  = qspc_pkg::ACC_W'(stall_ff);
                  mplier_in = qspc_pkg::RATE_W'(igain_ff);
               end
               MUL_RAMP: begin
                  mcand_in  = qspc_pkg::ACC_W'(elapsed_ff);
                  mplier_in = rate_ff;
               end
               default: begin
                  mcand_in  = qspc_pkg::ACC_W'(duty_ff);
                  mplier_in = qspc_pkg::RATE_W'(factor_ff);
               end
            endcase
            state_in = ST_MRUN;
         end
         ST_MRUN: begin
            if (mplier_ff != '0) begin
               // Retire one multiplier bit
               acc_in    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
               mcand_in  = {mcand_ff[qspc_pkg::ACC_W-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[qspc_pkg::RATE_W-1:1]};
            end else begin
               case (sel_ff)
                  MUL_PROP: begin
                     pterm_in = pterm_sat;
                     sel_in   = MUL_INTEG;
                     state_in = ST_MLOAD;
                  end
                  MUL_INTEG: begin
                     duty_in  = qspc_pkg::clamp_duty({2'b00, pterm_ff} + {1'b0, iterm_sat},
                                                     min_ff, max_ff);
                     sel_in   = MUL_RAMP;
                     state_in = ST_MLOAD;
                  end
                  MUL_RAMP: begin
                     // Scale only while the ramp factor is below one
                     if (acc_ff[qspc_pkg::ACC_W-1:qspc_pkg::Q_FRAC] == '0) begin
                        factor_in = acc_ff[qspc_pkg::Q_FRAC-1:0];
                        sel_in    = MUL_SCALE;
                        state_in  = ST_MLOAD;
                     end else begin
                        state_in = ST_APPLY;
                     end
                  end
                  default: begin
                     duty_in  = qspc_pkg::clamp_duty({2'b00, acc_ff[31:24]}, min_ff, max_ff);
                     state_in = ST_APPLY;
                  end
               endcase
            end
         end
         ST_APPLY: begin
            if (mag_ext < margin_ext) begin
               done_in  = 1'b1;
               stall_in = '0;
               en_in    = 1'b0;
               dir_in   = 1'b0;
               pwm_in   = '0;
            end else begin
               en_in = 1'b1;
               // Zero error keeps the previous direction and level
               if (err_ff != '0) begin
                  if (!err_ff[PW-1]) begin
                     dir_in = 1'b1;
                     pwm_in = qspc_pkg::DUTY_FULL - duty_ff;
                  end else begin
                     dir_in = 1'b0;
                     pwm_in = duty_ff;
                  end
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hold until the response register is free, then load it
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_en_in    = en_ff;
               rsp_dir_in   = dir_ff;
               rsp_pwm_in   = pwm_ff;
               rsp_done_in  = done_ff;
               rsp_act_in   = act_ext[qspc_pkg::COUNT_W-1:0];
               rsp_tgt_in   = tgt_ext[qspc_pkg::COUNT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff    <= qspc_pkg::RST_STEP_MARGIN;
         min_ff       <= qspc_pkg::RST_MIN_DUTY;
         max_ff       <= qspc_pkg::RST_MAX_DUTY;
         pgain_ff     <= qspc_pkg::RST_PROP_GAIN;
         igain_ff     <= qspc_pkg::RST_INTEG_GAIN;
         rate_ff      <= qspc_pkg::RST_SOFT_RATE;
         target_ff    <= '0;
         actual_ff    <= '0;
         phase_ff     <= '0;
         stall_ff     <= '0;
         elapsed_ff   <= '0;
         done_ff      <= 1'b0;
         en_ff        <= 1'b1;
         dir_ff       <= 1'b0;
         pwm_ff       <= '0;
         state_ff     <= ST_IDLE;
         sel_ff       <= MUL_PROP;
         rsp_valid_ff <= 1'b0;
      end else begin
         margin_ff    <= margin_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         pgain_ff     <= pgain_in;
         igain_ff     <= igain_in;
         rate_ff      <= rate_in;
         target_ff    <= target_in;
         actual_ff    <= actual_in;
         phase_ff     <= phase_in;
         stall_ff     <= stall_in;
         elapsed_ff   <= elapsed_in;
         done_ff      <= done_in;
         en_ff        <= en_in;
         dir_ff       <= dir_in;
         pwm_ff       <= pwm_in;
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff     <= err_in;
      mag_ff     <= mag_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      pterm_ff   <= pterm_in;
      duty_ff    <= duty_in;
      factor_ff  <= factor_in;
      rsp_en_ff  <= rsp_en_in;
      rsp_dir_ff <= rsp_dir_in;
      rsp_pwm_ff <= rsp_pwm_in;
      rsp_done_ff <= rsp_done_in;
      rsp_act_ff <= rsp_act_in;
      rsp_tgt_ff <= rsp_tgt_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor_enable = rsp_en_ff;
   assign rsp_motor_dir    = rsp_dir_ff;
   assign rsp_pwm_level    = rsp_pwm_ff;
   assign rsp_step_done    = rsp_done_ff;
   assign rsp_actual_count = rsp_act_ff;
   assign rsp_target_count = rsp_tgt_ff;

endmodule

`default_nettype wire
